/* sv/whc_pkg.sv */
// ----------------------------------------------------------------------------
// whc_pkg: shared definitions for the wire hit cluster finder
// Sizes, field widths, request and result codes, register indexes and the
// structs that travel between the sequencer and the top level.
// ----------------------------------------------------------------------------
package whc_pkg;

    // Chamber geometry
    localparam int NUM_PLANES      = 4;
    localparam int WIRES_PER_PLANE = 256;
    localparam int TOTAL_WIRES     = NUM_PLANES * WIRES_PER_PLANE;
    localparam int MAX_SUMMARIES   = 4;
    localparam int NUM_SUMMARY     = (NUM_PLANES < MAX_SUMMARIES) ? NUM_PLANES : MAX_SUMMARIES;

    localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int WIRE_W  = $clog2(WIRES_PER_PLANE);
    localparam int IW_W    = $clog2(WIRES_PER_PLANE + 1);
    localparam int ADDR_W  = $clog2(TOTAL_WIRES);

    // Field widths
    localparam int REQ_W      = 2;
    localparam int PLANE_ID_W = 2;
    localparam int WIRE_ID_W  = 8;
    localparam int GAP_W      = 8;
    localparam int SIZE_W     = 9;
    localparam int COUNT_W    = 8;
    localparam int LABEL_W    = 8;
    localparam int EMPTY_W    = GAP_W + 1;
    localparam int CMP_W      = (IW_W > SIZE_W) ? IW_W : SIZE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SIZE_W-1:0]  SIZE_MAX  = '1;
    localparam logic [EMPTY_W-1:0] EMPTY_MAX = '1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ANALYZE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd2;

    // Result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_LOOKUP  = 1'b1;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 2'd2;

    localparam logic [GAP_W-1:0]  GAP_RESET      = 8'd1;
    localparam logic [SIZE_W-1:0] MIN_SIZE_RESET = 9'd1;
    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 9'd256;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [GAP_W-1:0]  max_gap;
        logic [SIZE_W-1:0] min_cluster_size;
        logic [SIZE_W-1:0] max_cluster_size;
    } cfg_t;

    typedef struct packed {
        logic                  answer_kind;
        logic [PLANE_ID_W-1:0] plane_out;
        logic [COUNT_W-1:0]    cluster_count;
        logic [SIZE_W-1:0]     cluster_size;
        logic [LABEL_W-1:0]    cluster_label;
        logic                  last_result;
    } res_t;

    // Hit map port controls
    typedef struct packed {
        logic  we;
        addr_t waddr;
        logic  wdata;
        addr_t raddr;
    } hit_port_t;

    // Label store port controls
    typedef struct packed {
        logic               we;
        addr_t              waddr;
        logic [LABEL_W-1:0] wdata;
        addr_t              raddr;
    } lbl_port_t;

    function automatic addr_t make_addr(input logic [PLANE_W-1:0] plane,
                                        input logic [WIRE_W-1:0] wire_idx);
        return ADDR_W'(32'(plane) * WIRES_PER_PLANE + 32'(wire_idx));
    endfunction

endpackage

/* sv/whc_req_if.sv */
// ----------------------------------------------------------------------------
// whc_req_if: request channel
// Valid/ready channel that carries one hit, analyze or lookup request.
// ----------------------------------------------------------------------------
interface whc_req_if import whc_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [REQ_W-1:0]      req_type;
    logic [PLANE_ID_W-1:0] plane_id;
    logic [WIRE_ID_W-1:0]  wire_id;

    modport source (output valid, output req_type, output plane_id, output wire_id,
                    input ready);
    modport sink   (input valid, input req_type, input plane_id, input wire_id,
                    output ready);

endinterface

/* sv/whc_res_if.sv */
// ----------------------------------------------------------------------------
// whc_res_if: result channel
// Valid/ready channel that carries one plane summary or lookup answer.
// ----------------------------------------------------------------------------
interface whc_res_if import whc_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic                  answer_kind;
    logic [PLANE_ID_W-1:0] plane_out;
    logic [COUNT_W-1:0]    cluster_count;
    logic [SIZE_W-1:0]     cluster_size;
    logic [LABEL_W-1:0]    cluster_label;
    logic                  last_result;

    modport source (output valid, output answer_kind, output plane_out,
                    output cluster_count, output cluster_size, output cluster_label,
                    output last_result, input ready);
    modport sink   (input valid, input answer_kind, input plane_out,
                    input cluster_count, input cluster_size, input cluster_label,
                    input last_result, output ready);

endinterface

/* sv/whc_ram.sv */
// ----------------------------------------------------------------------------
// whc_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
module whc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/whc_ctrl.sv */
// ----------------------------------------------------------------------------
// whc_ctrl: request sequencer and cluster scanner
// Clears both stores after reset, applies hit loads, answers lookups and
// runs the per-plane cluster scan with label back-fill and summary output.
// ----------------------------------------------------------------------------
module whc_ctrl import whc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    whc_req_if.sink            req,
    whc_res_if.source          res,
    output hit_port_t          hit_port,
    input  logic               hit_rdata,
    output lbl_port_t          lbl_port,
    input  logic [LABEL_W-1:0] lbl_rdata
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_FILL,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    addr_t                 clear_addr_reg, clear_addr_next;
    logic [PLANE_W-1:0]    plane_reg, plane_next;
    logic [IW_W-1:0]       issue_wire_reg, issue_wire_next;
    logic                  proc_valid_reg, proc_valid_next;
    logic [WIRE_W-1:0]     proc_wire_reg, proc_wire_next;
    logic [IW_W-1:0]       hits_reg, hits_next;
    logic [EMPTY_W-1:0]    empties_reg, empties_next;
    logic [WIRE_W-1:0]     first_reg, first_next;
    logic [WIRE_W-1:0]     last_reg, last_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [WIRE_W-1:0]     fill_wire_reg, fill_wire_next;
    logic [WIRE_W-1:0]     fill_end_reg, fill_end_next;
    logic                  plane_end_reg, plane_end_next;
    logic                  lk_ok_reg, lk_ok_next;
    logic [PLANE_ID_W-1:0] lk_plane_reg, lk_plane_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  res_reg, res_next;

    logic               out_free;
    logic               req_ok;
    addr_t              req_addr;
    logic               issue_valid;
    addr_t              issue_addr;
    addr_t              proc_addr;
    logic               wire_last;
    logic               emit_ok;
    logic               plane_final;
    logic [IW_W-1:0]    hits_n;
    logic [EMPTY_W-1:0] empties_n;
    logic [WIRE_W-1:0]  first_n;
    logic [WIRE_W-1:0]  last_n;
    logic               closing;
    logic               accept;
    logic [COUNT_W-1:0] count_n;
    logic [SIZE_W-1:0]  size_n;

    assign out_free    = !out_valid_reg || res.ready;
    assign req_ok      = (32'(req.plane_id) < NUM_PLANES) &&
                         (32'(req.wire_id) < WIRES_PER_PLANE);
    assign req_addr    = make_addr(PLANE_W'(req.plane_id), WIRE_W'(req.wire_id));
    assign issue_valid = issue_wire_reg < IW_W'(WIRES_PER_PLANE);
    assign issue_addr  = make_addr(plane_reg, WIRE_W'(issue_wire_reg));
    assign proc_addr   = make_addr(plane_reg, proc_wire_reg);
    assign wire_last   = proc_wire_reg == WIRE_W'(WIRES_PER_PLANE - 1);
    assign emit_ok     = 32'(plane_reg) < NUM_SUMMARY;
    assign plane_final = plane_reg == PLANE_W'(NUM_PLANES - 1);

    // Run tracking for the wire whose hit bit arrives this cycle
    always_comb
    begin
        if (hit_rdata)
        begin
            hits_n    = hits_reg + IW_W'(1);
            empties_n = '0;
            first_n   = (hits_reg == '0) ? proc_wire_reg : first_reg;
            last_n    = proc_wire_reg;
        end
        else
        begin
            hits_n    = hits_reg;
            empties_n = (empties_reg == EMPTY_MAX) ? empties_reg : empties_reg + EMPTY_W'(1);
            first_n   = first_reg;
            last_n    = last_reg;
        end
        closing = (empties_n > EMPTY_W'(cfg.max_gap)) || wire_last;
        accept  = closing && (hits_n != '0) &&
                  (CMP_W'(hits_n) >= CMP_W'(cfg.min_cluster_size)) &&
                  (CMP_W'(hits_n) <= CMP_W'(cfg.max_cluster_size));
        count_n = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
        size_n  = (CMP_W'(hits_n) > CMP_W'(SIZE_MAX)) ? SIZE_MAX : SIZE_W'(hits_n);
    end

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        plane_next      = plane_reg;
        issue_wire_next = issue_wire_reg;
        proc_valid_next = proc_valid_reg;
        proc_wire_next  = proc_wire_reg;
        hits_next       = hits_reg;
        empties_next    = empties_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        size_next       = size_reg;
        fill_wire_next  = fill_wire_reg;
        fill_end_next   = fill_end_reg;
        plane_end_next  = plane_end_reg;
        lk_ok_next      = lk_ok_reg;
        lk_plane_next   = lk_plane_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        res_next        = res_reg;
        req.ready       = 1'b0;

        hit_port.we    = 1'b0;
        hit_port.waddr = proc_addr;
        hit_port.wdata = 1'b0;
        hit_port.raddr = issue_addr;
        lbl_port.we    = 1'b0;
        lbl_port.waddr = proc_addr;
        lbl_port.wdata = '0;
        lbl_port.raddr = req_addr;

        unique case (state_reg)
            ST_CLEAR:
            begin
                hit_port.we    = 1'b1;
                hit_port.waddr = clear_addr_reg;
                lbl_port.we    = 1'b1;
                lbl_port.waddr = clear_addr_reg;
                if (clear_addr_reg == ADDR_W'(TOTAL_WIRES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clear_addr_next = clear_addr_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                req.ready = out_free;
                if (req.valid && out_free)
                begin
                    unique case (req.req_type)
                        REQ_LOAD:
                        begin
                            hit_port.we    = req_ok;
                            hit_port.waddr = req_addr;
                            hit_port.wdata = 1'b1;
                        end
                        REQ_ANALYZE:
                        begin
                            plane_next      = '0;
                            issue_wire_next = '0;
                            proc_valid_next = 1'b0;
                            hits_next       = '0;
                            empties_next    = '0;
                            first_next      = '0;
                            last_next       = '0;
                            count_next      = '0;
                            size_next       = '0;
                            state_next      = ST_SCAN;
                        end
                        REQ_LOOKUP:
                        begin
                            lk_ok_next    = req_ok;
                            lk_plane_next = req.plane_id;
                            state_next    = ST_LOOKUP;
                        end
                        default:
                        begin
                            // unknown request: drop
                        end
                    endcase
                end
            end

            ST_LOOKUP:
            begin
                out_valid_next         = 1'b1;
                res_next.answer_kind   = KIND_LOOKUP;
                res_next.plane_out     = lk_plane_reg;
                res_next.cluster_count = '0;
                res_next.cluster_size  = '0;
                res_next.cluster_label = lk_ok_reg ? lbl_rdata : '0;
                res_next.last_result   = 1'b1;
                state_next             = ST_IDLE;
            end

            ST_SCAN:
            begin
                proc_valid_next = issue_valid;
                proc_wire_next  = WIRE_W'(issue_wire_reg);
                if (issue_valid)
                begin
                    issue_wire_next = issue_wire_reg + IW_W'(1);
                end
                if (proc_valid_reg)
                begin
                    // clear the hit bit and the old label as the wire goes by
                    hit_port.we  = 1'b1;
                    lbl_port.we  = 1'b1;
                    hits_next    = closing ? '0 : hits_n;
                    empties_next = empties_n;
                    first_next   = first_n;
                    last_next    = last_n;
                    if (accept)
                    begin
                        count_next      = count_n;
                        size_next       = size_n;
                        fill_wire_next  = first_n;
                        fill_end_next   = last_n;
                        plane_end_next  = wire_last;
                        // drop the read in flight, reissue it after the fill
                        proc_valid_next = 1'b0;
                        issue_wire_next = IW_W'(proc_wire_reg) + IW_W'(1);
                        state_next      = ST_FILL;
                    end
                    else if (wire_last)
                    begin
                        proc_valid_next = 1'b0;
                        state_next      = ST_EMIT;
                    end
                end
            end

            ST_FILL:
            begin
                lbl_port.we    = 1'b1;
                lbl_port.waddr = make_addr(plane_reg, fill_wire_reg);
                lbl_port.wdata = LABEL_W'(count_reg);
                if (fill_wire_reg == fill_end_reg)
                begin
                    state_next = plane_end_reg ? ST_EMIT : ST_SCAN;
                end
                else
                begin
                    fill_wire_next = fill_wire_reg + WIRE_W'(1);
                end
            end

            ST_EMIT:
            begin
                if (!emit_ok || out_free)
                begin
                    if (emit_ok)
                    begin
                        out_valid_next         = 1'b1;
                        res_next.answer_kind   = KIND_SUMMARY;
                        res_next.plane_out     = PLANE_ID_W'(plane_reg);
                        res_next.cluster_count = count_reg;
                        res_next.cluster_size  = size_reg;
                        res_next.cluster_label = '0;
                        res_next.last_result   = plane_reg == PLANE_W'(NUM_SUMMARY - 1);
                    end
                    if (plane_final)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        plane_next      = plane_reg + PLANE_W'(1);
                        issue_wire_next = '0;
                        proc_valid_next = 1'b0;
                        hits_next       = '0;
                        empties_next    = '0;
                        first_next      = '0;
                        last_next       = '0;
                        count_next      = '0;
                        size_next       = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            plane_reg      <= '0;
            issue_wire_reg <= '0;
            proc_valid_reg <= 1'b0;
            proc_wire_reg  <= '0;
            hits_reg       <= '0;
            empties_reg    <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            count_reg      <= '0;
            size_reg       <= '0;
            fill_wire_reg  <= '0;
            fill_end_reg   <= '0;
            plane_end_reg  <= 1'b0;
            lk_ok_reg      <= 1'b0;
            lk_plane_reg   <= '0;
            out_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            plane_reg      <= plane_next;
            issue_wire_reg <= issue_wire_next;
            proc_valid_reg <= proc_valid_next;
            proc_wire_reg  <= proc_wire_next;
            hits_reg       <= hits_next;
            empties_reg    <= empties_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            count_reg      <= count_next;
            size_reg       <= size_next;
            fill_wire_reg  <= fill_wire_next;
            fill_end_reg   <= fill_end_next;
            plane_end_reg  <= plane_end_next;
            lk_ok_reg      <= lk_ok_next;
            lk_plane_reg   <= lk_plane_next;
            out_valid_reg  <= out_valid_next;
            res_reg        <= res_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.answer_kind   = res_reg.answer_kind;
    assign res.plane_out     = res_reg.plane_out;
    assign res.cluster_count = res_reg.cluster_count;
    assign res.cluster_size  = res_reg.cluster_size;
    assign res.cluster_label = res_reg.cluster_label;
    assign res.last_result   = res_reg.last_result;

    // The processed wire always trails the issued read by one
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_valid_reg |-> (state_reg == ST_SCAN &&
                            issue_wire_reg == IW_W'(proc_wire_reg) + IW_W'(1)))
        else $error("scan read pipeline out of step");

    // Back-fill never runs past the last hit of the cluster
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> fill_wire_reg <= fill_end_reg)
        else $error("label fill overran cluster end");

    // A run never holds more hits than the plane has wires
    assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= IW_W'(WIRES_PER_PLANE))
        else $error("hit count beyond plane size");

    // An accepted lookup shows its answer once ST_LOOKUP has loaded the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.req_type == REQ_LOOKUP) |=> ##1
        (out_valid_reg && res_reg.answer_kind == KIND_LOOKUP))
        else $error("lookup answer missing");

endmodule

/* sv/wire_hit_cluster_finder.sv */
// ----------------------------------------------------------------------------
// wire_hit_cluster_finder: wire chamber hit clustering
// Hit map and label store in two synchronous RAMs, scanned plane by plane
// to number accepted clusters and report one summary per plane.
//
//   channel   direction   handshake        contents
//   req       in          valid/ready      req_type, plane_id, wire_id
//   res       out         valid/ready      summary or lookup answer
//   cfg       in          cfg_write_en     cfg_index, cfg_data
//
// After reset both RAMs are swept to zero, one entry a cycle, over all
// TOTAL_WIRES (1024) entries; req is held off until the sweep ends.
// A hit load is written from ST_IDLE; a lookup reads the label RAM, and
// ST_LOOKUP then loads its answer into the result register. Analyze walks
// the hit RAM one wire a cycle, plane by plane, pausing for the label
// back-fill of each accepted cluster and a reissued hit read after it (no
// reissue when the cluster closes at the last wire). req.ready is low while the
// result register holds an untaken transaction; summaries wait on res.ready.
// ----------------------------------------------------------------------------
module wire_hit_cluster_finder import whc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    whc_req_if.sink               req,
    whc_res_if.source             res,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [GAP_W-1:0]  max_gap_reg, max_gap_next;
    logic [SIZE_W-1:0] min_size_reg, min_size_next;
    logic [SIZE_W-1:0] max_size_reg, max_size_next;

    cfg_t               cfg;
    hit_port_t          hit_port;
    lbl_port_t          lbl_port;
    logic               hit_rdata;
    logic [LABEL_W-1:0] lbl_rdata;

    always_comb
    begin
        max_gap_next  = max_gap_reg;
        min_size_next = min_size_reg;
        max_size_next = max_size_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MAX_GAP:  max_gap_next  = cfg_data[GAP_W-1:0];
                CFG_MIN_SIZE: min_size_next = cfg_data[SIZE_W-1:0];
                CFG_MAX_SIZE: max_size_next = cfg_data[SIZE_W-1:0];
                default:
                begin
                    // no register at this index
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg  <= GAP_RESET;
            min_size_reg <= MIN_SIZE_RESET;
            max_size_reg <= MAX_SIZE_RESET;
        end
        else
        begin
            max_gap_reg  <= max_gap_next;
            min_size_reg <= min_size_next;
            max_size_reg <= max_size_next;
        end
    end

    assign cfg.max_gap          = max_gap_reg;
    assign cfg.min_cluster_size = min_size_reg;
    assign cfg.max_cluster_size = max_size_reg;

    whc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .res       (res),
        .hit_port  (hit_port),
        .hit_rdata (hit_rdata),
        .lbl_port  (lbl_port),
        .lbl_rdata (lbl_rdata)
    );

    whc_ram #(
        .DEPTH (TOTAL_WIRES),
        .WIDTH (1)
    ) u_hit_ram (
        .clk   (clk),
        .we    (hit_port.we),
        .waddr (hit_port.waddr),
        .wdata (hit_port.wdata),
        .raddr (hit_port.raddr),
        .rdata (hit_rdata)
    );

    whc_ram #(
        .DEPTH (TOTAL_WIRES),
        .WIDTH (LABEL_W)
    ) u_label_ram (
        .clk   (clk),
        .we    (lbl_port.we),
        .waddr (lbl_port.waddr),
        .wdata (lbl_port.wdata),
        .raddr (lbl_port.raddr),
        .rdata (lbl_rdata)
    );

endmodule

/* sim/tb_wire_hit_cluster_finder.sv */
// ----------------------------------------------------------------------------
// tb_wire_hit_cluster_finder: self-checking bench for the hit cluster finder
// Loads hits, runs analyze passes and looks up wire labels across several
// gap and size-window settings. A scoreboard mirrors the hit map and label
// store, predicts every plane summary and lookup answer, and compares each
// result transaction in order with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_wire_hit_cluster_finder;
    import whc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 290;
    localparam int QUIET_TAIL   = 50;
    localparam int IDLE_SETTLE  = 8;
    localparam int END_SETTLE   = 64;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    whc_req_if req_ch ();
    whc_res_if res_ch ();

    wire_hit_cluster_finder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .res          (res_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Scoreboard copy of the chamber state and thresholds
    bit                 hit_mirror   [TOTAL_WIRES];
    logic [LABEL_W-1:0] label_mirror [TOTAL_WIRES];
    logic [GAP_W-1:0]   gap_setting;
    logic [SIZE_W-1:0]  min_setting;
    logic [SIZE_W-1:0]  max_setting;

    res_t predicted_answers [$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   item_count     = 0;
    int   idle_chance    = 0;
    int   stall_left     = 0;

    // Walk one plane in wire order, label accepted clusters, report count and size
    function automatic void cluster_scan(input int plane, output logic [COUNT_W-1:0] count,
                                         output logic [SIZE_W-1:0] size);
        int base;
        int hits;
        int empties;
        int first;
        int last;
        base    = plane * WIRES_PER_PLANE;
        hits    = 0;
        empties = 0;
        first   = 0;
        last    = 0;
        count   = '0;
        size    = '0;
        for (int w = 0; w < WIRES_PER_PLANE; w++)
        begin
            if (hit_mirror[base + w])
            begin
                if (hits == 0)
                    first = w;
                last    = w;
                hits++;
                empties = 0;
            end
            else if (empties < 'hFFFF)
                empties++;
            if (empties > int'(gap_setting) || w == WIRES_PER_PLANE - 1)
            begin
                if (hits > 0 && hits >= int'(min_setting) && hits <= int'(max_setting))
                begin
                    if (count != COUNT_MAX)
                        count++;
                    size = (hits > int'(SIZE_MAX)) ? SIZE_MAX : SIZE_W'(hits);
                    for (int j = first; j <= last; j++)
                        label_mirror[base + j] = count;
                end
                hits = 0;
            end
        end
    endfunction

    // Update the mirror for one accepted request and queue the answers it causes
    function automatic void apply_request(input logic [REQ_W-1:0] kind,
                                          input logic [PLANE_ID_W-1:0] plane,
                                          input logic [WIRE_ID_W-1:0] wire_no);
        res_t answer;
        logic [COUNT_W-1:0] count;
        logic [SIZE_W-1:0]  size;
        bit in_range;
        int addr;
        in_range = int'(plane) < NUM_PLANES && int'(wire_no) < WIRES_PER_PLANE;
        addr     = int'(plane) * WIRES_PER_PLANE + int'(wire_no);
        answer   = '0;
        case (kind)
            REQ_LOAD:
            begin
                if (in_range)
                    hit_mirror[addr] = 1'b1;
            end
            REQ_ANALYZE:
            begin
                foreach (label_mirror[i])
                    label_mirror[i] = '0;
                for (int p = 0; p < NUM_PLANES; p++)
                begin
                    cluster_scan(p, count, size);
                    if (p < NUM_SUMMARY)
                    begin
                        answer.answer_kind   = KIND_SUMMARY;
                        answer.plane_out     = PLANE_ID_W'(p);
                        answer.cluster_count = count;
                        answer.cluster_size  = size;
                        answer.cluster_label = '0;
                        answer.last_result   = (p == NUM_SUMMARY - 1);
                        predicted_answers    = {predicted_answers, answer};
                    end
                end
                foreach (hit_mirror[i])
                    hit_mirror[i] = 1'b0;
            end
            REQ_LOOKUP:
            begin
                answer.answer_kind   = KIND_LOOKUP;
                answer.plane_out     = plane;
                answer.cluster_label = in_range ? label_mirror[addr] : '0;
                answer.last_result   = 1'b1;
                predicted_answers    = {predicted_answers, answer};
            end
            default: ;
        endcase
    endfunction

    // Drive one request, hold it until accepted, then predict its answers
    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [PLANE_ID_W-1:0] plane,
                                input logic [WIRE_ID_W-1:0] wire_no);
        if (idle_chance != 0 && $urandom_range(1, 100) <= idle_chance)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.plane_id <= plane;
        req_ch.wire_id  <= wire_no;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_request(kind, plane, wire_no);
        if (kind != REQ_UNUSED)
            item_count++;
    endtask

    // Hold off requests until every answer is in and the block has settled
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (predicted_answers.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [GAP_W-1:0] gap,
                                  input logic [SIZE_W-1:0] lo,
                                  input logic [SIZE_W-1:0] hi);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_MAX_GAP;
        cfg_data     <= CFG_DATA_W'(gap);
        @(posedge clk);
        cfg_index    <= CFG_MIN_SIZE;
        cfg_data     <= lo;
        @(posedge clk);
        cfg_index    <= CFG_MAX_SIZE;
        cfg_data     <= hi;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        gap_setting  = gap;
        min_setting  = lo;
        max_setting  = hi;
    endtask

    task automatic test_reset_state();
        idle_chance = 20;
        send_request(REQ_LOOKUP, 2'd0, 8'd0);
        send_request(REQ_ANALYZE, 2'd0, 8'd0);
    endtask

    task automatic test_cluster_edges();
        // Reset thresholds: gap 1 bridges one empty wire
        send_request(REQ_LOAD, 2'd0, 8'd0);
        send_request(REQ_LOAD, 2'd0, 8'd1);
        send_request(REQ_LOAD, 2'd0, 8'd1);
        send_request(REQ_LOAD, 2'd0, 8'd3);
        send_request(REQ_LOAD, 2'd0, 8'd6);
        send_request(REQ_LOAD, 2'd3, 8'd255);
        send_request(REQ_LOAD, 2'd3, 8'd254);
        send_request(REQ_LOAD, 2'd1, 8'd128);
        send_request(REQ_UNUSED, 2'd2, 8'd200);
        send_request(REQ_ANALYZE, 2'd3, 8'd255);
        send_request(REQ_LOOKUP, 2'd0, 8'd0);
        send_request(REQ_LOOKUP, 2'd0, 8'd2);
        send_request(REQ_LOOKUP, 2'd0, 8'd5);
        send_request(REQ_LOOKUP, 2'd0, 8'd6);
        send_request(REQ_LOOKUP, 2'd3, 8'd255);
        send_request(REQ_LOOKUP, 2'd1, 8'd128);
    endtask

    task automatic test_size_window();
        wait_idle();
        // Zero minimum behaves as one; a pair is too big for a window of one
        set_thresholds(8'd0, 9'd0, 9'd1);
        send_request(REQ_LOAD, 2'd0, 8'd10);
        send_request(REQ_LOAD, 2'd0, 8'd11);
        send_request(REQ_LOAD, 2'd1, 8'd50);
        send_request(REQ_ANALYZE, 2'd0, 8'd0);
        wait_idle();
        // Minimum above maximum rejects everything
        set_thresholds(8'd255, 9'd3, 9'd2);
        send_request(REQ_LOAD, 2'd2, 8'd0);
        send_request(REQ_LOAD, 2'd2, 8'd255);
        send_request(REQ_ANALYZE, 2'd1, 8'd0);
        send_request(REQ_LOOKUP, 2'd1, 8'd50);
    endtask

    task automatic test_dense_planes();
        wait_idle();
        set_thresholds(8'd0, 9'd1, 9'd256);
        idle_chance = 10;
        // Even wires give 128 single-wire clusters
        for (int w = 0; w < WIRES_PER_PLANE; w += 2)
            send_request(REQ_LOAD, 2'd0, WIRE_ID_W'(w));
        send_request(REQ_ANALYZE, 2'd2, 8'd128);
        send_request(REQ_LOOKUP, 2'd0, 8'd254);
        send_request(REQ_LOOKUP, 2'd0, 8'd255);
        wait_idle();
        // The widest gap joins both end wires into one cluster over the whole plane
        set_thresholds(8'd255, 9'd2, 9'd256);
        send_request(REQ_LOAD, 2'd2, 8'd0);
        send_request(REQ_LOAD, 2'd2, 8'd255);
        send_request(REQ_ANALYZE, 2'd2, 8'd128);
        send_request(REQ_LOOKUP, 2'd2, 8'd0);
        send_request(REQ_LOOKUP, 2'd2, 8'd128);
        send_request(REQ_LOOKUP, 2'd2, 8'd255);
    endtask

    task automatic pick_random_thresholds();
        logic [GAP_W-1:0]  gap;
        logic [SIZE_W-1:0] lo;
        logic [SIZE_W-1:0] hi;
        case ($urandom_range(0, 4))
            0:       gap = 8'd0;
            1:       gap = 8'd255;
            2:       gap = 8'd1;
            default: gap = GAP_W'($urandom_range(0, 6));
        endcase
        case ($urandom_range(0, 4))
            0:       lo = 9'd256;
            1:       lo = 9'd0;
            2:       lo = SIZE_W'($urandom_range(2, 4));
            default: lo = 9'd1;
        endcase
        case ($urandom_range(0, 4))
            0:       hi = 9'd1;
            1:       hi = SIZE_W'($urandom_range(2, 6));
            2:       hi = SIZE_W'($urandom_range(7, 255));
            default: hi = 9'd256;
        endcase
        set_thresholds(gap, lo, hi);
    endtask

    // Hits grouped around a few centers, usually an analyze, then lookups near the hits
    task automatic run_random_event();
        logic [PLANE_ID_W-1:0] plane;
        logic [PLANE_ID_W-1:0] seen_plane [$];
        logic [WIRE_ID_W-1:0]  seen_wire [$];
        int clusters;
        int center;
        int span;
        int wire_no;
        int looks;
        int pick;
        clusters = $urandom_range(0, 6);
        for (int c = 0; c < clusters; c++)
        begin
            plane  = PLANE_ID_W'($urandom_range(0, NUM_PLANES - 1));
            center = $urandom_range(0, WIRES_PER_PLANE - 1);
            span   = $urandom_range(1, 8);
            for (int k = 0; k < span; k++)
            begin
                wire_no = center + k;
                if (wire_no < WIRES_PER_PLANE && $urandom_range(0, 9) < 7)
                begin
                    send_request(REQ_LOAD, plane, WIRE_ID_W'(wire_no));
                    seen_plane = {seen_plane, plane};
                    seen_wire  = {seen_wire, WIRE_ID_W'(wire_no)};
                end
                if ($urandom_range(0, 24) == 0)
                    send_request(REQ_W'($urandom_range(0, 3)), PLANE_ID_W'($urandom()),
                                 WIRE_ID_W'($urandom()));
            end
        end
        // Skip the analyze now and then so hits pile up across events
        if ($urandom_range(0, 11) != 0)
            send_request(REQ_ANALYZE, PLANE_ID_W'($urandom()), WIRE_ID_W'($urandom()));
        looks = $urandom_range(1, 5);
        for (int n = 0; n < looks; n++)
        begin
            if (seen_wire.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                pick    = $urandom_range(0, seen_wire.size() - 1);
                wire_no = int'(seen_wire[pick]) + int'($urandom_range(0, 2)) - 1;
                if (wire_no < 0)
                    wire_no = 0;
                if (wire_no >= WIRES_PER_PLANE)
                    wire_no = WIRES_PER_PLANE - 1;
                send_request(REQ_LOOKUP, seen_plane[pick], WIRE_ID_W'(wire_no));
            end
            else
                send_request(REQ_LOOKUP, PLANE_ID_W'($urandom()), WIRE_ID_W'($urandom()));
        end
    endtask

    task automatic test_random_events();
        int start;
        start = item_count;
        while (item_count - start < RANDOM_ITEMS)
        begin
            if (item_count - start >= RANDOM_ITEMS - QUIET_TAIL)
                idle_chance = 0;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       idle_chance = 0;
                    1:       idle_chance = 10;
                    default: idle_chance = 35;
                endcase
            end
            if ($urandom_range(0, 4) == 0)
            begin
                wait_idle();
                pick_random_thresholds();
            end
            run_random_event();
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_LOAD;
        req_ch.plane_id <= '0;
        req_ch.wire_id  <= '0;
        cfg_write_en    <= 1'b0;
        cfg_index       <= CFG_MAX_GAP;
        cfg_data        <= '0;
        foreach (hit_mirror[i])
            hit_mirror[i] = 1'b0;
        foreach (label_mirror[i])
            label_mirror[i] = '0;
        gap_setting = GAP_RESET;
        min_setting = MIN_SIZE_RESET;
        max_setting = MAX_SIZE_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_cluster_edges();
        test_size_window();
        test_dense_planes();
        test_random_events();

        idle_chance = 0;
        wait_idle();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && predicted_answers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result sink: random stall bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (idle_chance != 0 && $urandom_range(1, 100) <= idle_chance)
        begin
            stall_left = $urandom_range(0, 3);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_answer
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (predicted_answers.size() == 0)
            begin
                $error("unexpected result transaction: kind %0d plane %0d",
                       res_ch.answer_kind, res_ch.plane_out);
                mismatch_count++;
            end
            else
            begin
                want = predicted_answers.pop_front();
                if (res_ch.answer_kind !== want.answer_kind)
                begin
                    $error("answer_kind: expected %0d, got %0d",
                           want.answer_kind, res_ch.answer_kind);
                    mismatch_count++;
                end
                if (res_ch.plane_out !== want.plane_out)
                begin
                    $error("plane_out: expected %0d, got %0d", want.plane_out, res_ch.plane_out);
                    mismatch_count++;
                end
                if (res_ch.cluster_count !== want.cluster_count)
                begin
                    $error("cluster_count: expected %0d, got %0d",
                           want.cluster_count, res_ch.cluster_count);
                    mismatch_count++;
                end
                if (res_ch.cluster_size !== want.cluster_size)
                begin
                    $error("cluster_size: expected %0d, got %0d",
                           want.cluster_size, res_ch.cluster_size);
                    mismatch_count++;
                end
                if (res_ch.cluster_label !== want.cluster_label)
                begin
                    $error("cluster_label: expected %0d, got %0d",
                           want.cluster_label, res_ch.cluster_label);
                    mismatch_count++;
                end
                if (res_ch.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, res_ch.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

/* files.f */
sv/whc_pkg.sv
sv/whc_req_if.sv
sv/whc_res_if.sv
sv/whc_ram.sv
sv/whc_ctrl.sv
sv/wire_hit_cluster_finder.sv
sim/tb_wire_hit_cluster_finder.sv
